>>> hw/rtl/rwem_pkg.sv
// ----------------------------------------------------------------------------
// rwem_pkg
// Shared types and constants of the rolling window error metrics block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rwem_pkg;

  localparam int unsigned IN_SAMPLE_W = 16;
  localparam int unsigned VFLOOR_W    = 16;
  localparam int unsigned MET_W       = 16;
  localparam int unsigned R2_W        = 18;
  localparam int unsigned R2_FRAC     = 14;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned STATUS_W    = 3;

  localparam int R2_ONE  = 16384;
  localparam int R2_MIN  = -131072;
  localparam int R2_QSAT = 147456;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic REG_STRICT = 1'b0;
  localparam logic REG_VFLOOR = 1'b1;

  localparam logic [STATUS_W-1:0] STAT_NONE     = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_ERR_ONLY = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_TEMP_R2  = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_HUM_R2   = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_ALL      = 3'd4;

  typedef struct packed {
    logic clear;
    logic add;
    logic sub;
  } upd_cmd_t;

  typedef struct packed {
    logic [MET_W-1:0]       mae;
    logic [MET_W-1:0]       rmse;
    logic signed [R2_W-1:0] r2;
    logic                   r2_ok;
  } lane_res_t;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic [MET_W-1:0]       mae_temp;
    logic [MET_W-1:0]       rmse_temp;
    logic signed [R2_W-1:0] r2_temp;
    logic [MET_W-1:0]       mae_hum;
    logic [MET_W-1:0]       rmse_hum;
    logic signed [R2_W-1:0] r2_hum;
    logic [MET_W-1:0]       mae_both;
    logic [MET_W-1:0]       rmse_both;
    logic signed [R2_W-1:0] r2_both;
  } out_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/rwem_ram.sv
// ----------------------------------------------------------------------------
// rwem_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwem_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 24
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rwem_div.sv
// ----------------------------------------------------------------------------
// rwem_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwem_div #(
  parameter int unsigned NUM_W = 8,
  parameter int unsigned DEN_W = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  busy_o,
  output logic [NUM_W-1:0]      quo_o,
  output logic [DEN_W-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fits};
      rem_q <= fits ? DEN_W'(diff) : DEN_W'(trial);
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> hw/rtl/rwem_isqrt.sv
// ----------------------------------------------------------------------------
// rwem_isqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwem_isqrt #(
  parameter int unsigned WIDTH = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [WIDTH-1:0]       x_i,
  output logic                        busy_o,
  output logic [(WIDTH+1)/2-1:0]      root_o
);

  localparam int unsigned PW    = WIDTH + (WIDTH % 2);
  localparam int unsigned RTW   = PW / 2;
  localparam int unsigned RW    = RTW + 2;
  localparam int unsigned CNT_W = $clog2(RTW + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [PW-1:0]    x_q;
  logic [RW-1:0]    rem_q;
  logic [RTW-1:0]   root_q;
  logic [RW+1:0]    cur;
  logic [RW+1:0]    trial;
  logic             fits;

  assign cur   = {rem_q, x_q[PW-1:PW-2]};
  assign trial = (RW + 2)'({root_q, 2'b01});
  assign fits  = cur >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(RTW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= PW'(x_i);
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      x_q    <= {x_q[PW-3:0], 2'b00};
      rem_q  <= fits ? RW'(cur - trial) : RW'(cur);
      root_q <= {root_q[RTW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

>>> hw/rtl/rwem_lane.sv
// ----------------------------------------------------------------------------
// rwem_lane
// One variable: running sums over the window and the MAE, RMSE and R2 units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwem_lane #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned WINDOW      = 24
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire rwem_pkg::upd_cmd_t                        upd_i,
  input  wire logic signed [SAMPLE_BITS:0]               new_err_i,
  input  wire logic signed [SAMPLE_BITS-1:0]             new_y_i,
  input  wire logic signed [SAMPLE_BITS:0]               old_err_i,
  input  wire logic signed [SAMPLE_BITS-1:0]             old_y_i,
  input  wire logic                                      start_i,
  input  wire logic [$clog2(WINDOW+1)-1:0]               n_i,
  input  wire logic [rwem_pkg::VFLOOR_W-1:0]             var_floor_i,
  output logic                                           busy_o,
  output rwem_pkg::lane_res_t                            res_o,
  output logic [SAMPLE_BITS+1+$clog2(WINDOW+1)-1:0]      sabs_o,
  output logic [2*SAMPLE_BITS+2+$clog2(WINDOW+1)-1:0]    ssq_o
);

  localparam int unsigned S    = SAMPLE_BITS;
  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned ABW  = S + 1;
  localparam int unsigned SABW = ABW + CW;
  localparam int unsigned SQW  = 2 * ABW + CW;
  localparam int unsigned SYW  = S + CW + 1;
  localparam int unsigned YYW  = 2 * S + CW;
  localparam int unsigned NYW  = YYW + CW;
  localparam int unsigned Y2W  = 2 * SYW;
  localparam int unsigned CMPW = (NYW > Y2W) ? NYW : Y2W;
  localparam int unsigned NSW  = SQW + CW;
  localparam int unsigned NW   = NSW + rwem_pkg::R2_FRAC;
  localparam int unsigned FLW  = rwem_pkg::VFLOOR_W + 2 * CW;
  localparam int unsigned RTW  = (SQW + 1) / 2;

  typedef enum logic [2:0] {L_IDLE, L_PREP1, L_PREP2, L_PREP3, L_WAIT} lane_state_e;

  lane_state_e state_q;
  logic        sq_go_q;

  logic [SABW-1:0]       sabs_q, sabs_d;
  logic [SQW-1:0]        ssq_q, ssq_d;
  logic signed [SYW-1:0] sy_q, sy_d;
  logic [YYW-1:0]        syy_q, syy_d;

  logic [ABW-1:0]   ab_new, ab_old;
  logic [S-1:0]     yab_new, yab_old;
  logic [2*ABW-1:0] sq_new, sq_old;
  logic [2*S-1:0]   yy_new, yy_old;
  logic [SYW-1:0]   sy_abs;

  logic [NYW-1:0]  nyy_p, nyy_q;
  logic [Y2W-1:0]  y2_p, y2_q;
  logic [2*CW-1:0] nn_p, nn_q;
  logic [NSW-1:0]  nssq_p, nssq_q;
  logic [FLW-1:0]  fl_p, fl_q;
  logic [CMPW-1:0] diff;
  logic [NYW-1:0]  d_q;
  logic            r2_ok_q;

  logic            mae_busy, mse_busy, ratio_busy, sq_busy;
  logic            ratio_go, sq_go;
  logic [SABW-1:0] mae_quo;
  logic [CW-1:0]   mae_rem;
  logic [SQW-1:0]  mse_quo;
  logic [CW-1:0]   mse_rem;
  logic [NW-1:0]   ratio_quo;
  logic [NYW-1:0]  ratio_rem;
  logic [RTW-1:0]  root;

  logic [63:0]       mae_ext, rmse_ext;
  logic              r2_big;
  logic [19:0]       qc;
  logic signed [20:0] r2_val;

  // magnitudes and squares of the incoming and outgoing entries
  always_comb begin
    ab_new  = new_err_i[S] ? ABW'(-new_err_i) : ABW'(new_err_i);
    ab_old  = old_err_i[S] ? ABW'(-old_err_i) : ABW'(old_err_i);
    yab_new = new_y_i[S-1] ? S'(-new_y_i) : S'(new_y_i);
    yab_old = old_y_i[S-1] ? S'(-old_y_i) : S'(old_y_i);
    sy_abs  = sy_q[SYW-1] ? SYW'(-sy_q) : SYW'(sy_q);
  end

  assign sq_new = ab_new * ab_new;
  assign sq_old = ab_old * ab_old;
  assign yy_new = yab_new * yab_new;
  assign yy_old = yab_old * yab_old;

  always_comb begin
    sabs_d = sabs_q;
    ssq_d  = ssq_q;
    sy_d   = sy_q;
    syy_d  = syy_q;
    if (upd_i.clear) begin
      sabs_d = '0;
      ssq_d  = '0;
      sy_d   = '0;
      syy_d  = '0;
    end else begin
      if (upd_i.sub) begin
        sabs_d = sabs_d - SABW'(ab_old);
        ssq_d  = ssq_d - SQW'(sq_old);
        sy_d   = sy_d - SYW'(old_y_i);
        syy_d  = syy_d - YYW'(yy_old);
      end
      if (upd_i.add) begin
        sabs_d = sabs_d + SABW'(ab_new);
        ssq_d  = ssq_d + SQW'(sq_new);
        sy_d   = sy_d + SYW'(new_y_i);
        syy_d  = syy_d + YYW'(yy_new);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sabs_q <= '0;
      ssq_q  <= '0;
      sy_q   <= '0;
      syy_q  <= '0;
    end else begin
      sabs_q <= sabs_d;
      ssq_q  <= ssq_d;
      sy_q   <= sy_d;
      syy_q  <= syy_d;
    end
  end

  assign nyy_p  = n_i * syy_q;
  assign y2_p   = sy_abs * sy_abs;
  assign nn_p   = n_i * n_i;
  assign nssq_p = n_i * ssq_q;
  assign fl_p   = var_floor_i * nn_q;
  assign diff   = CMPW'(nyy_q) - CMPW'(y2_q);

  assign ratio_go = (state_q == L_PREP3);
  assign sq_go    = (state_q == L_WAIT) && !mse_busy && !sq_go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      sq_go_q <= 1'b0;
    end else begin
      case (state_q)
        L_IDLE: begin
          if (start_i) begin
            state_q <= L_PREP1;
          end
        end
        L_PREP1: state_q <= L_PREP2;
        L_PREP2: state_q <= L_PREP3;
        L_PREP3: state_q <= L_WAIT;
        L_WAIT: begin
          if (sq_go) begin
            sq_go_q <= 1'b1;
          end else if (sq_go_q && !sq_busy && !ratio_busy && !mae_busy) begin
            sq_go_q <= 1'b0;
            state_q <= L_IDLE;
          end
        end
        default: state_q <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      L_PREP1: begin
        nyy_q  <= nyy_p;
        y2_q   <= y2_p;
        nn_q   <= nn_p;
        nssq_q <= nssq_p;
      end
      L_PREP2: begin
        d_q  <= (CMPW'(nyy_q) > CMPW'(y2_q)) ? NYW'(diff) : '0;
        fl_q <= fl_p;
      end
      L_PREP3: begin
        r2_ok_q <= (n_i >= CW'(2)) && (CMPW'(d_q) > CMPW'(fl_q));
      end
      default: ;
    endcase
  end

  rwem_div #(.NUM_W(SABW), .DEN_W(CW)) u_mae_div (
    .clk_i, .rst_ni, .start_i(start_i), .num_i(sabs_q), .den_i(n_i),
    .busy_o(mae_busy), .quo_o(mae_quo), .rem_o(mae_rem)
  );

  rwem_div #(.NUM_W(SQW), .DEN_W(CW)) u_mse_div (
    .clk_i, .rst_ni, .start_i(start_i), .num_i(ssq_q), .den_i(n_i),
    .busy_o(mse_busy), .quo_o(mse_quo), .rem_o(mse_rem)
  );

  rwem_div #(.NUM_W(NW), .DEN_W(NYW)) u_ratio_div (
    .clk_i, .rst_ni, .start_i(ratio_go),
    .num_i({nssq_q, rwem_pkg::R2_FRAC'(0)}), .den_i(d_q),
    .busy_o(ratio_busy), .quo_o(ratio_quo), .rem_o(ratio_rem)
  );

  rwem_isqrt #(.WIDTH(SQW)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_go), .x_i(mse_quo),
    .busy_o(sq_busy), .root_o(root)
  );

  // remainders of the mean dividers are not needed
  logic unused_rem;
  assign unused_rem = ^{mae_rem, mse_rem};

  always_comb begin
    mae_ext  = 64'(mae_quo);
    rmse_ext = 64'(root);
    r2_big   = ratio_quo > NW'(rwem_pkg::R2_QSAT);
    qc       = 20'(ratio_quo) + 20'(ratio_rem != '0);
    r2_val   = 21'(rwem_pkg::R2_ONE) - signed'({1'b0, qc});

    res_o.mae   = (mae_ext > 64'd65535) ? 16'hFFFF : mae_ext[15:0];
    res_o.rmse  = (rmse_ext > 64'd65535) ? 16'hFFFF : rmse_ext[15:0];
    res_o.r2_ok = r2_ok_q;
    if (!r2_ok_q) begin
      res_o.r2 = '0;
    end else if (r2_big || (r2_val < 21'(rwem_pkg::R2_MIN))) begin
      res_o.r2 = rwem_pkg::R2_W'(rwem_pkg::R2_MIN);
    end else begin
      res_o.r2 = rwem_pkg::R2_W'(r2_val);
    end
  end

  assign busy_o = (state_q != L_IDLE);
  assign sabs_o = sabs_q;
  assign ssq_o  = ssq_q;

endmodule

`default_nettype wire

>>> hw/rtl/rwem_merge.sv
// ----------------------------------------------------------------------------
// rwem_merge
// Combines both lanes: joint MAE and RMSE, mean R2 and the status code.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rwem_merge #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned WINDOW      = 24
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      start_i,
  input  wire logic [$clog2(WINDOW+1)-1:0]               n_i,
  input  wire logic                                      strict_i,
  input  wire logic [SAMPLE_BITS+1+$clog2(WINDOW+1)-1:0] sabs_t_i,
  input  wire logic [SAMPLE_BITS+1+$clog2(WINDOW+1)-1:0] sabs_h_i,
  input  wire logic [2*SAMPLE_BITS+2+$clog2(WINDOW+1)-1:0] ssq_t_i,
  input  wire logic [2*SAMPLE_BITS+2+$clog2(WINDOW+1)-1:0] ssq_h_i,
  input  wire rwem_pkg::lane_res_t                       res_t_i,
  input  wire rwem_pkg::lane_res_t                       res_h_i,
  output logic                                           busy_o,
  output rwem_pkg::out_res_t                             res_o
);

  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned SABW = SAMPLE_BITS + 1 + CW;
  localparam int unsigned SQW  = 2 * SAMPLE_BITS + 2 + CW;
  localparam int unsigned RTW  = (SQW + 2) / 2;

  typedef enum logic {M_IDLE, M_WAIT} merge_state_e;

  merge_state_e state_q;
  logic         sq_go_q;
  logic         sq_go;

  logic [SABW:0]  sabs_sum;
  logic [SQW:0]   ssq_sum;
  logic [CW:0]    den2;
  logic           abs_busy, sq_div_busy, sq_busy;
  logic [SABW:0]  abs_quo;
  logic [CW:0]    abs_rem;
  logic [SQW:0]   sq_quo;
  logic [CW:0]    sq_rem;
  logic [RTW-1:0] root;

  logic              none;
  logic [63:0]       mae_ext, rmse_ext;
  logic signed [18:0] r2_sum;

  assign sabs_sum = sabs_t_i + sabs_h_i;
  assign ssq_sum  = ssq_t_i + ssq_h_i;
  assign den2     = {n_i, 1'b0};
  assign sq_go    = (state_q == M_WAIT) && !sq_div_busy && !sq_go_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      sq_go_q <= 1'b0;
    end else begin
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            state_q <= M_WAIT;
          end
        end
        M_WAIT: begin
          if (sq_go) begin
            sq_go_q <= 1'b1;
          end else if (sq_go_q && !sq_busy && !abs_busy) begin
            sq_go_q <= 1'b0;
            state_q <= M_IDLE;
          end
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  rwem_div #(.NUM_W(SABW + 1), .DEN_W(CW + 1)) u_abs_div (
    .clk_i, .rst_ni, .start_i(start_i), .num_i(sabs_sum), .den_i(den2),
    .busy_o(abs_busy), .quo_o(abs_quo), .rem_o(abs_rem)
  );

  rwem_div #(.NUM_W(SQW + 1), .DEN_W(CW + 1)) u_sq_div (
    .clk_i, .rst_ni, .start_i(start_i), .num_i(ssq_sum), .den_i(den2),
    .busy_o(sq_div_busy), .quo_o(sq_quo), .rem_o(sq_rem)
  );

  rwem_isqrt #(.WIDTH(SQW + 1)) u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_go), .x_i(sq_quo),
    .busy_o(sq_busy), .root_o(root)
  );

  logic unused_rem;
  assign unused_rem = ^{abs_rem, sq_rem};

  always_comb begin
    none     = (n_i == '0) || (strict_i && (n_i < CW'(WINDOW)));
    mae_ext  = 64'(abs_quo);
    rmse_ext = 64'(root);
    r2_sum   = 19'(res_t_i.r2) + 19'(res_h_i.r2);
    res_o    = '0;
    if (!none) begin
      res_o.mae_temp  = res_t_i.mae;
      res_o.rmse_temp = res_t_i.rmse;
      res_o.r2_temp   = res_t_i.r2;
      res_o.mae_hum   = res_h_i.mae;
      res_o.rmse_hum  = res_h_i.rmse;
      res_o.r2_hum    = res_h_i.r2;
      res_o.mae_both  = (mae_ext > 64'd65535) ? 16'hFFFF : mae_ext[15:0];
      res_o.rmse_both = (rmse_ext > 64'd65535) ? 16'hFFFF : rmse_ext[15:0];
      if (res_t_i.r2_ok && res_h_i.r2_ok) begin
        res_o.status  = rwem_pkg::STAT_ALL;
        res_o.r2_both = rwem_pkg::R2_W'(r2_sum >>> 1);
      end else if (res_t_i.r2_ok) begin
        res_o.status = rwem_pkg::STAT_TEMP_R2;
      end else if (res_h_i.r2_ok) begin
        res_o.status = rwem_pkg::STAT_HUM_R2;
      end else begin
        res_o.status = rwem_pkg::STAT_ERR_ONLY;
      end
    end
  end

  assign busy_o = (state_q != M_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/rolling_window_error_metrics.sv
// ----------------------------------------------------------------------------
// rolling_window_error_metrics
// Sliding window MAE, RMSE and R2 over paired temperature and humidity samples.
//
// Input stream: one transfer per item; tdata carries the four sample values,
// tuser the opcode and the three acceptance flags. Output stream: one result
// transfer per item; tuser says whether the sample entered the window.
// Configuration: cfg_valid_i/cfg_ready_o write channel, index 0 strict mode,
// index 1 variance floor; write only while the block is idle.
// An accepted item passes the update and start states and then waits in the run
// state for the serial R2 ratio divider, the MSE and mean dividers and the square
// root units. One item is in work at a time; the next input is taken the cycle
// after the result is registered.
// Reset clears sums, count, slot, configuration and the output valid; the
// window RAM is not cleared and needs no clearing pass. A stalled receiver
// holds the result; a finished item then waits for the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rolling_window_error_metrics #(
  parameter int unsigned WINDOW      = 24,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // temp_true, hum_true, temp_pred, hum_pred
  input  wire logic [63:0]  s_axis_tdata,
  // opcode, is_hourly, was_invoked, sample_valid
  input  wire logic [3:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // sample_count, status, mae_temp, rmse_temp, r2_temp, mae_hum, rmse_hum,
  // r2_hum, mae_both, rmse_both, r2_both, two zero pad bits
  output logic [159:0]      m_axis_tdata,
  // accepted
  output logic              m_axis_tuser,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic         cfg_index_i,
  input  wire logic [15:0]  cfg_data_i
);

  localparam int unsigned S    = SAMPLE_BITS;
  localparam int unsigned CW   = $clog2(WINDOW + 1);
  localparam int unsigned AW   = $clog2(WINDOW);
  localparam int unsigned ENTW = 2 * (2 * S + 1);
  localparam int unsigned SABW = S + 1 + CW;
  localparam int unsigned SQW  = 2 * S + 2 + CW;

  typedef enum logic [1:0] {ST_IDLE, ST_UPD, ST_START, ST_RUN} top_state_e;

  top_state_e state_q;
  logic       strict_q;
  logic [rwem_pkg::VFLOOR_W-1:0] vfloor_q;
  logic [AW-1:0] slot_q;
  logic [CW-1:0] cnt_q;
  logic          op_q, gate_q, full;
  logic          in_xfer;

  logic signed [S-1:0] t_y_in, h_y_in, t_p_in, h_p_in;
  logic signed [S:0]   t_err_q, h_err_q;
  logic signed [S-1:0] t_y_q, h_y_q;
  logic [ENTW-1:0]     rd_data;

  rwem_pkg::upd_cmd_t  upd;
  rwem_pkg::lane_res_t res_t, res_h;
  rwem_pkg::out_res_t  res_m, out_q;
  logic                busy_t, busy_h, busy_m, lanes_start, result_ready;
  logic [SABW-1:0]     sabs_t, sabs_h;
  logic [SQW-1:0]      ssq_t, ssq_h;

  logic       m_valid_q;
  logic       acc_out_q;
  logic [rwem_pkg::COUNT_W-1:0] cnt_out_q;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign full          = (cnt_q == CW'(WINDOW));

  assign t_y_in = signed'(S'(s_axis_tdata[15:0]));
  assign h_y_in = signed'(S'(s_axis_tdata[31:16]));
  assign t_p_in = signed'(S'(s_axis_tdata[47:32]));
  assign h_p_in = signed'(S'(s_axis_tdata[63:48]));

  always_comb begin
    upd = '0;
    if (state_q == ST_UPD) begin
      upd.clear = (op_q == rwem_pkg::OP_CLEAR);
      upd.add   = gate_q;
      upd.sub   = gate_q && full;
    end
  end

  assign lanes_start  = (state_q == ST_START);
  assign result_ready = !busy_t && !busy_h && !busy_m && (!m_valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= 1'b0;
      vfloor_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rwem_pkg::REG_STRICT: strict_q <= cfg_data_i[0];
        rwem_pkg::REG_VFLOOR: vfloor_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      slot_q    <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          state_q <= ST_START;
          if (op_q == rwem_pkg::OP_CLEAR) begin
            slot_q <= '0;
            cnt_q  <= '0;
          end else if (gate_q) begin
            slot_q <= (slot_q == AW'(WINDOW - 1)) ? '0 : slot_q + AW'(1);
            if (!full) begin
              cnt_q <= cnt_q + CW'(1);
            end
          end
        end
        ST_START: state_q <= ST_RUN;
        ST_RUN: begin
          if (result_ready) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q    <= s_axis_tuser[0];
      gate_q  <= (s_axis_tuser[0] == rwem_pkg::OP_SAMPLE) && s_axis_tuser[1] &&
                 s_axis_tuser[2] && s_axis_tuser[3];
      t_y_q   <= t_y_in;
      h_y_q   <= h_y_in;
      t_err_q <= (S + 1)'(t_p_in) - (S + 1)'(t_y_in);
      h_err_q <= (S + 1)'(h_p_in) - (S + 1)'(h_y_in);
    end
    if ((state_q == ST_RUN) && result_ready) begin
      out_q     <= res_m;
      acc_out_q <= gate_q;
      cnt_out_q <= rwem_pkg::COUNT_W'(cnt_q);
    end
  end

  rwem_ram #(.WIDTH(ENTW), .DEPTH(WINDOW)) u_ring (
    .clk_i,
    .we_i   ((state_q == ST_UPD) && gate_q),
    .waddr_i(slot_q),
    .wdata_i({h_y_q, h_err_q, t_y_q, t_err_q}),
    .re_i   (in_xfer),
    .raddr_i(slot_q),
    .rdata_o(rd_data)
  );

  rwem_lane #(.SAMPLE_BITS(S), .WINDOW(WINDOW)) u_lane_temp (
    .clk_i, .rst_ni,
    .upd_i      (upd),
    .new_err_i  (t_err_q),
    .new_y_i    (t_y_q),
    .old_err_i  (signed'(rd_data[S:0])),
    .old_y_i    (signed'(rd_data[2*S:S+1])),
    .start_i    (lanes_start),
    .n_i        (cnt_q),
    .var_floor_i(vfloor_q),
    .busy_o     (busy_t),
    .res_o      (res_t),
    .sabs_o     (sabs_t),
    .ssq_o      (ssq_t)
  );

  rwem_lane #(.SAMPLE_BITS(S), .WINDOW(WINDOW)) u_lane_hum (
    .clk_i, .rst_ni,
    .upd_i      (upd),
    .new_err_i  (h_err_q),
    .new_y_i    (h_y_q),
    .old_err_i  (signed'(rd_data[3*S+1:2*S+1])),
    .old_y_i    (signed'(rd_data[4*S+1:3*S+2])),
    .start_i    (lanes_start),
    .n_i        (cnt_q),
    .var_floor_i(vfloor_q),
    .busy_o     (busy_h),
    .res_o      (res_h),
    .sabs_o     (sabs_h),
    .ssq_o      (ssq_h)
  );

  rwem_merge #(.SAMPLE_BITS(S), .WINDOW(WINDOW)) u_merge (
    .clk_i, .rst_ni,
    .start_i (lanes_start),
    .n_i     (cnt_q),
    .strict_i(strict_q),
    .sabs_t_i(sabs_t),
    .sabs_h_i(sabs_h),
    .ssq_t_i (ssq_t),
    .ssq_h_i (ssq_h),
    .res_t_i (res_t),
    .res_h_i (res_h),
    .busy_o  (busy_m),
    .res_o   (res_m)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = acc_out_q;
  assign m_axis_tdata  = {2'b00, out_q.r2_both, out_q.rmse_both, out_q.mae_both,
                          out_q.r2_hum, out_q.rmse_hum, out_q.mae_hum,
                          out_q.r2_temp, out_q.rmse_temp, out_q.mae_temp,
                          out_q.status, cnt_out_q};

  // window bookkeeping stays in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q <= CW'(WINDOW)) && (slot_q <= AW'(WINDOW - 1)))
    else $error("window count or slot out of range");

  // a new item is only taken once every unit has finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!busy_t && !busy_h && !busy_m))
    else $error("input taken while arithmetic units are busy");

  // a full window stays full when a sample replaces the oldest entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && op_q == rwem_pkg::OP_SAMPLE && full) |=> full)
    else $error("full window lost a sample");

  // the slot wraps back to zero whenever the window has just filled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD && upd.add && !full && cnt_q == CW'(WINDOW - 1)) |=>
    (slot_q == '0))
    else $error("write slot out of step with sample count");

endmodule

`default_nettype wire

>>> bench/rwem_checker.sv
// ----------------------------------------------------------------------------
// rwem_checker
// Watches the input, result and register channels of the rolling window error
// metrics block, predicts each result from the accepted inputs and compares
// every result field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwem_checker #(
  parameter int unsigned WINDOW = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,
  input  logic [3:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [159:0] m_axis_tdata,
  input  logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic         cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  output int           errors_o,
  output int           pending_o
);

  typedef struct {
    logic                             accepted;
    logic [rwem_pkg::COUNT_W-1:0]     count;
    logic [rwem_pkg::STATUS_W-1:0]    status;
    logic [rwem_pkg::MET_W-1:0]       mae_t;
    logic [rwem_pkg::MET_W-1:0]       rmse_t;
    logic signed [rwem_pkg::R2_W-1:0] r2_t;
    logic [rwem_pkg::MET_W-1:0]       mae_h;
    logic [rwem_pkg::MET_W-1:0]       rmse_h;
    logic signed [rwem_pkg::R2_W-1:0] r2_h;
    logic [rwem_pkg::MET_W-1:0]       mae_b;
    logic [rwem_pkg::MET_W-1:0]       rmse_b;
    logic signed [rwem_pkg::R2_W-1:0] r2_b;
  } metrics_t;

  typedef struct {
    longint err;
    longint y;
  } slot_t;

  typedef struct {
    longint unsigned sabs;
    longint unsigned ssq;
    longint          sy;
    longint unsigned syy;
  } sums_t;

  logic            strict_mode;
  logic [15:0]     var_floor;
  slot_t           temp_win [WINDOW];
  slot_t           hum_win  [WINDOW];
  int unsigned     wr_slot;
  int unsigned     held;
  sums_t           temp_acc;
  sums_t           hum_acc;
  metrics_t        expected_q [$];

  function automatic longint unsigned uabs64(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [rwem_pkg::MET_W-1:0] clip16(longint unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic sums_t slot_update(sums_t s, slot_t e, bit add);
    longint unsigned ab;
    longint unsigned yy;
    ab = uabs64(e.err);
    yy = uabs64(e.y) * uabs64(e.y);
    if (add) begin
      s.sabs += ab; s.ssq += ab * ab; s.sy += e.y; s.syy += yy;
    end else begin
      s.sabs -= ab; s.ssq -= ab * ab; s.sy -= e.y; s.syy -= yy;
    end
    return s;
  endfunction

  task automatic lane_metrics(input sums_t s, input longint unsigned n,
                              output logic [rwem_pkg::MET_W-1:0] mae,
                              output logic [rwem_pkg::MET_W-1:0] rmse,
                              output logic signed [rwem_pkg::R2_W-1:0] r2,
                              output bit ok);
    longint unsigned nyy;
    longint unsigned y2;
    longint unsigned d;
    bit [127:0]      num;
    bit [127:0]      q;
    longint          v;
    mae  = clip16(s.sabs / n);
    rmse = clip16(int_sqrt(s.ssq / n));
    r2   = '0;
    ok   = 1'b0;
    if (n >= 2) begin
      nyy = n * s.syy;
      y2  = uabs64(s.sy) * uabs64(s.sy);
      d   = (nyy > y2) ? nyy - y2 : 0;
      if (d > longint'(var_floor) * n * n) begin
        num = (128'(s.ssq) * 128'(n)) << rwem_pkg::R2_FRAC;
        q   = (num + 128'(d) - 1) / 128'(d);
        if (q > 128'(1 << 22)) q = 128'(1 << 22);
        v  = rwem_pkg::R2_ONE - longint'(q[63:0]);
        r2 = (v < rwem_pkg::R2_MIN) ? rwem_pkg::R2_W'(rwem_pkg::R2_MIN) :
             rwem_pkg::R2_W'(v);
        ok = 1'b1;
      end
    end
  endtask

  task automatic predict_item(input logic [63:0] d, input logic [3:0] u);
    metrics_t        res;
    slot_t           et;
    slot_t           eh;
    bit              ok_t;
    bit              ok_h;
    longint unsigned n;
    longint          r2sum;
    res = '{default: '0};
    ok_t = 0;
    ok_h = 0;
    if (u[0] == rwem_pkg::OP_CLEAR) begin
      wr_slot = 0;
      held = 0;
      temp_acc = '{default: 0};
      hum_acc = '{default: 0};
    end else if (u[1] && u[2] && u[3]) begin
      et.y   = longint'($signed(d[15:0]));
      eh.y   = longint'($signed(d[31:16]));
      et.err = longint'($signed(d[47:32])) - et.y;
      eh.err = longint'($signed(d[63:48])) - eh.y;
      if (held >= WINDOW) begin
        temp_acc = slot_update(temp_acc, temp_win[wr_slot], 0);
        hum_acc  = slot_update(hum_acc, hum_win[wr_slot], 0);
      end
      temp_win[wr_slot] = et;
      hum_win[wr_slot]  = eh;
      temp_acc = slot_update(temp_acc, et, 1);
      hum_acc  = slot_update(hum_acc, eh, 1);
      wr_slot = (wr_slot + 1) % WINDOW;
      if (held < WINDOW) held++;
      res.accepted = 1'b1;
    end
    n = held;
    res.count = n[rwem_pkg::COUNT_W-1:0];
    res.status = rwem_pkg::STAT_NONE;
    if (n != 0 && !(strict_mode && n < WINDOW)) begin
      lane_metrics(temp_acc, n, res.mae_t, res.rmse_t, res.r2_t, ok_t);
      lane_metrics(hum_acc, n, res.mae_h, res.rmse_h, res.r2_h, ok_h);
      res.mae_b  = clip16((temp_acc.sabs + hum_acc.sabs) / (2 * n));
      res.rmse_b = clip16(int_sqrt((temp_acc.ssq + hum_acc.ssq) / (2 * n)));
      if (ok_t && ok_h) begin
        r2sum = longint'(res.r2_t) + longint'(res.r2_h);
        res.r2_b = rwem_pkg::R2_W'(r2sum >>> 1);
        res.status = rwem_pkg::STAT_ALL;
      end else if (ok_t) res.status = rwem_pkg::STAT_TEMP_R2;
      else if (ok_h) res.status = rwem_pkg::STAT_HUM_R2;
      else res.status = rwem_pkg::STAT_ERR_ONLY;
    end
    expected_q.push_back(res);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      errors_o++;
    end
  endtask

  task automatic check_result(input logic [159:0] d, input logic acc);
    metrics_t e;
    if (expected_q.size() == 0) begin
      $error("result transfer with no prediction waiting");
      errors_o++;
    end else begin
      e = expected_q.pop_front();
      check_field("accepted", e.accepted, acc);
      check_field("sample_count", e.count, d[4:0]);
      check_field("status", e.status, d[7:5]);
      check_field("mae_temp", e.mae_t, d[23:8]);
      check_field("rmse_temp", e.rmse_t, d[39:24]);
      check_field("r2_temp", e.r2_t, $signed(d[57:40]));
      check_field("mae_hum", e.mae_h, d[73:58]);
      check_field("rmse_hum", e.rmse_h, d[89:74]);
      check_field("r2_hum", e.r2_h, $signed(d[107:90]));
      check_field("mae_both", e.mae_b, d[123:108]);
      check_field("rmse_both", e.rmse_b, d[139:124]);
      check_field("r2_both", e.r2_b, $signed(d[157:140]));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_mode <= 1'b0;
      var_floor <= '0;
      wr_slot = 0;
      held = 0;
      temp_acc = '{default: 0};
      hum_acc = '{default: 0};
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == rwem_pkg::REG_STRICT) strict_mode <= cfg_data_i[0];
        else var_floor <= cfg_data_i;
      end
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tdata, s_axis_tuser);
      pending_o <= expected_q.size();
    end
  end

endmodule

>>> bench/tb_rolling_window_error_metrics.sv
// ----------------------------------------------------------------------------
// tb_rolling_window_error_metrics
// Drives directed and random sample streams into the rolling window error
// metrics block under several register settings and idle patterns; a checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rolling_window_error_metrics;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 150;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [63:0]  s_axis_tdata;
  logic [3:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic         m_axis_tuser;
  logic         cfg_valid_i;
  logic         cfg_ready_o;
  logic         cfg_index_i;
  logic [15:0]  cfg_data_i;
  int           errors;
  int           pending;
  int           cycles = 0;
  int           send_idle_pct;
  int           recv_idle_pct;
  logic [15:0]  base_t;
  logic [15:0]  base_h;

  rolling_window_error_metrics DUT (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  rwem_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic send_item(logic op, logic [15:0] tt, logic [15:0] ht, logic [15:0] tp,
                           logic [15:0] hp, logic hourly, logic invoked, logic valid);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hp, tp, ht, tt};
    s_axis_tuser  <= {valid, invoked, hourly, op};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_sample(logic [15:0] tt, logic [15:0] ht, logic [15:0] tp,
                             logic [15:0] hp);
    send_item(rwem_pkg::OP_SAMPLE, tt, ht, tp, hp, 1'b1, 1'b1, 1'b1);
  endtask

  task automatic write_reg(logic idx, logic [15:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [15:0] near(logic [15:0] b, int spread);
    return b + 16'($urandom_range(0, 2 * spread) - spread);
  endfunction

  task automatic random_item;
    int          kind;
    int          r;
    logic [2:0]  gates;
    logic [15:0] tt;
    logic [15:0] ht;
    logic [15:0] tp;
    logic [15:0] hp;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      tt = 16'($urandom); ht = 16'($urandom);
    end else if (kind < 6) begin
      tt = near(base_t, 400); ht = near(base_h, 400);
    end else begin
      tt = near(base_t, 1); ht = near(base_h, 1);
    end
    tp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : near(tt, 300);
    hp = ($urandom_range(0, 3) == 0) ? 16'($urandom) : near(ht, 300);
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_item(rwem_pkg::OP_CLEAR, tt, ht, tp, hp, 1'($urandom), 1'($urandom),
                1'($urandom));
    end else if (r < 12) begin
      gates = 3'($urandom_range(0, 6));
      send_item(rwem_pkg::OP_SAMPLE, tt, ht, tp, hp, gates[0], gates[1], gates[2]);
    end else begin
      send_sample(tt, ht, tp, hp);
    end
  endtask

  task automatic run_phase(logic strict, logic [15:0] vfloor, int n_items);
    write_reg(rwem_pkg::REG_STRICT, {15'd0, strict});
    write_reg(rwem_pkg::REG_VFLOOR, vfloor);
    base_t = 16'($urandom_range(0, 8000) - 2000);
    base_h = 16'($urandom_range(0, 10000));
    for (int i = 0; i < n_items; i++) random_item();
    settle();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = rwem_pkg::REG_STRICT;
    cfg_data_i = '0;
    send_idle_pct = 20;
    recv_idle_pct = 60;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty window, single sample, extremes, ignored items, clear
    write_reg(rwem_pkg::REG_STRICT, 16'd0);
    write_reg(rwem_pkg::REG_VFLOOR, 16'd0);
    send_item(rwem_pkg::OP_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1);
    send_sample(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
    send_sample(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_item(rwem_pkg::OP_SAMPLE, 16'd100, 16'd100, 16'd100, 16'd100, 1'b0, 1'b1, 1'b1);
    send_item(rwem_pkg::OP_SAMPLE, 16'd100, 16'd100, 16'd100, 16'd100, 1'b1, 1'b0, 1'b1);
    send_item(rwem_pkg::OP_SAMPLE, 16'd100, 16'd100, 16'd100, 16'd100, 1'b1, 1'b1, 1'b0);
    send_item(rwem_pkg::OP_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              1'b0, 1'b0, 1'b0);
    send_sample(16'd2500, 16'd5000, 16'd2500, 16'd5000);
    send_sample(16'd2500, 16'd5000, 16'd2600, 16'd4900);
    send_sample(16'd2500, 16'd5000, 16'd2400, 16'd5100);
    for (int i = 0; i < 8; i++)
      send_sample(16'(1000 * i), 16'(500 * i), 16'(1000 * i + 50), 16'(500 * i - 20));
    send_sample(16'd0, 16'd0, 16'd0, 16'd0);
    send_sample(16'hFFFF, 16'h8000, 16'h0000, 16'h8000);
    send_item(rwem_pkg::OP_CLEAR, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b1);
    settle();

    run_phase(1'b0, 16'd0, 200);
    run_phase(1'b1, 16'hFFFF, 200);
    send_idle_pct = 60;
    recv_idle_pct = 20;
    run_phase(1'b1, 16'd0, 200);
    run_phase(1'b0, 16'hFFFF, 200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(1'b0, 16'($urandom_range(1, 200)), 200);

    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
